/* sv/cfp_pkg.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Command frame parser package
// Shared types and constants for the command frame parser.
// ----------------------------------------------------------------------------
package cfp_pkg;

  localparam int unsigned ByteW = 8;
  localparam int unsigned WordW = 32;
  localparam int unsigned CountW = 3;
  localparam int unsigned StatusW = 2;

  localparam logic [ByteW-1:0] CH_START = 8'h40;
  localparam logic [ByteW-1:0] CH_SEP = 8'h23;
  localparam logic [ByteW-1:0] CH_TERM = 8'h21;
  localparam logic [ByteW-1:0] CH_NUL = 8'h00;

  localparam logic [CountW-1:0] CMD_LAST = 3'd3;
  localparam logic [CountW-1:0] WORDS_LAST = 3'd7;

  localparam logic [StatusW-1:0] ST_BUSY = 2'd0;
  localparam logic [StatusW-1:0] ST_DONE = 2'd1;
  localparam logic [StatusW-1:0] ST_ERR = 2'd2;

  typedef enum logic [2:0] {
    PH_IDLE  = 3'd0,
    PH_CMD   = 3'd1,
    PH_SEP   = 3'd2,
    PH_WORDS = 3'd3,
    PH_TERM  = 3'd4
  } phase_t;

  typedef struct packed {
    logic [StatusW-1:0] status;
    logic [WordW-1:0]   command;
    logic [WordW-1:0]   first_word;
    logic [WordW-1:0]   second_word;
  } result_t;

endpackage

/* sv/command_frame_parser_top.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Command frame parser
// Parses '@', four command bytes, '#', two little-endian 32-bit words and a
// terminator of '!' or zero from a stream of received bytes.
//
// The input channel carries one byte per transaction on rx_byte, qualified
// by in_valid and held off by in_stall. Every accepted byte gives exactly one
// result transaction on the output channel, qualified by out_valid and held
// off by out_stall. The status is busy while a frame is in progress, done on
// a good terminator and error on a wrong start, separator or terminator byte.
// A done result carries the command bytes and both words; other results
// carry zeros in those fields.
// A byte's result appears in the cycle after its acceptance, from a single
// output register. One byte is taken every cycle while the output side does
// not stall; a stalled result holds in place and stalls the input only while
// it waits. Reset returns the parser to idle and empties the output register.
// ----------------------------------------------------------------------------
module command_frame_parser_top (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          in_valid,
  output logic                          in_stall,
  input  logic [cfp_pkg::ByteW-1:0]     rx_byte,
  output logic                          out_valid,
  input  logic                          out_stall,
  output logic [cfp_pkg::StatusW-1:0]   status,
  output logic [cfp_pkg::WordW-1:0]     command,
  output logic [cfp_pkg::WordW-1:0]     first_word,
  output logic [cfp_pkg::WordW-1:0]     second_word
);

  logic accept;
  logic space;
  cfp_pkg::result_t result;
  cfp_pkg::result_t out_result;

  assign in_stall = !space;
  assign accept = in_valid && space;

  cfp_fsm u_fsm (
    .clk     (clk),
    .rst     (rst),
    .accept  (accept),
    .rx_byte (rx_byte),
    .result  (result)
  );

  cfp_out_reg u_out_reg (
    .clk        (clk),
    .rst        (rst),
    .load       (accept),
    .result     (result),
    .space      (space),
    .out_valid  (out_valid),
    .out_stall  (out_stall),
    .out_result (out_result)
  );

  assign status = out_result.status;
  assign command = out_result.command;
  assign first_word = out_result.first_word;
  assign second_word = out_result.second_word;

endmodule

/* sv/cfp_fsm.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Command frame parser state machine
// Tracks the frame phase, assembles the command and words, and forms the
// result of each accepted byte.
// ----------------------------------------------------------------------------
module cfp_fsm (
  input  logic                           clk,
  input  logic                           rst,
  input  logic                           accept,
  input  logic [cfp_pkg::ByteW-1:0]      rx_byte,
  output cfp_pkg::result_t               result
);

  cfp_pkg::phase_t phase, phase_next;
  logic [cfp_pkg::CountW-1:0] byte_count, byte_count_next;
  logic [cfp_pkg::WordW-1:0] command_reg, command_reg_next;
  logic [cfp_pkg::WordW-1:0] word_a_reg, word_a_reg_next;
  logic [cfp_pkg::WordW-1:0] word_b_reg, word_b_reg_next;
  logic [cfp_pkg::StatusW-1:0] status;

  always_comb begin
    phase_next = phase;
    byte_count_next = byte_count;
    command_reg_next = command_reg;
    word_a_reg_next = word_a_reg;
    word_b_reg_next = word_b_reg;
    case (phase)
      cfp_pkg::PH_CMD: begin
        command_reg_next[{byte_count[1:0], 3'b000} +: cfp_pkg::ByteW] = rx_byte;
        byte_count_next = byte_count + 3'd1;
        if (byte_count == cfp_pkg::CMD_LAST) begin
          phase_next = cfp_pkg::PH_SEP;
          byte_count_next = '0;
        end
      end
      cfp_pkg::PH_SEP: begin
        if (rx_byte == cfp_pkg::CH_SEP) begin
          phase_next = cfp_pkg::PH_WORDS;
          byte_count_next = '0;
          word_a_reg_next = '0;
          word_b_reg_next = '0;
        end else begin
          phase_next = cfp_pkg::PH_IDLE;
        end
      end
      cfp_pkg::PH_WORDS: begin
        if (!byte_count[2]) begin
          word_a_reg_next[{byte_count[1:0], 3'b000} +: cfp_pkg::ByteW] =
            word_a_reg[{byte_count[1:0], 3'b000} +: cfp_pkg::ByteW] | rx_byte;
        end else begin
          word_b_reg_next[{byte_count[1:0], 3'b000} +: cfp_pkg::ByteW] =
            word_b_reg[{byte_count[1:0], 3'b000} +: cfp_pkg::ByteW] | rx_byte;
        end
        byte_count_next = byte_count + 3'd1;
        if (byte_count == cfp_pkg::WORDS_LAST) begin
          phase_next = cfp_pkg::PH_TERM;
        end
      end
      cfp_pkg::PH_TERM: begin
        phase_next = cfp_pkg::PH_IDLE;
      end
      default: begin
        if (rx_byte == cfp_pkg::CH_START) begin
          phase_next = cfp_pkg::PH_CMD;
          byte_count_next = '0;
        end else begin
          phase_next = cfp_pkg::PH_IDLE;
        end
      end
    endcase
  end

  always_comb begin
    status = cfp_pkg::ST_BUSY;
    case (phase)
      cfp_pkg::PH_CMD: begin
        status = cfp_pkg::ST_BUSY;
      end
      cfp_pkg::PH_SEP: begin
        status = (rx_byte == cfp_pkg::CH_SEP) ? cfp_pkg::ST_BUSY : cfp_pkg::ST_ERR;
      end
      cfp_pkg::PH_WORDS: begin
        status = cfp_pkg::ST_BUSY;
      end
      cfp_pkg::PH_TERM: begin
        status = (rx_byte == cfp_pkg::CH_TERM || rx_byte == cfp_pkg::CH_NUL) ?
                 cfp_pkg::ST_DONE : cfp_pkg::ST_ERR;
      end
      default: begin
        status = (rx_byte == cfp_pkg::CH_START) ? cfp_pkg::ST_BUSY : cfp_pkg::ST_ERR;
      end
    endcase
  end

  always_comb begin
    result.status = status;
    if (status == cfp_pkg::ST_DONE) begin
      result.command = command_reg;
      result.first_word = word_a_reg;
      result.second_word = word_b_reg;
    end else begin
      result.command = '0;
      result.first_word = '0;
      result.second_word = '0;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      phase <= cfp_pkg::PH_IDLE;
      byte_count <= '0;
      command_reg <= '0;
      word_a_reg <= '0;
      word_b_reg <= '0;
    end else if (accept) begin
      phase <= phase_next;
      byte_count <= byte_count_next;
      command_reg <= command_reg_next;
      word_a_reg <= word_a_reg_next;
      word_b_reg <= word_b_reg_next;
    end
  end

  a_cmd_count_range: assert property (@(posedge clk) disable iff (rst)
    phase == cfp_pkg::PH_CMD |-> byte_count <= cfp_pkg::CMD_LAST)
    else $error("Command byte count out of range.");

  a_term_to_idle: assert property (@(posedge clk) disable iff (rst)
    accept && phase == cfp_pkg::PH_TERM |=> phase == cfp_pkg::PH_IDLE)
    else $error("Parser did not return to idle after the terminator.");

  a_bad_start_stays_idle: assert property (@(posedge clk) disable iff (rst)
    accept && phase == cfp_pkg::PH_IDLE && rx_byte != cfp_pkg::CH_START
    |=> phase == cfp_pkg::PH_IDLE)
    else $error("Parser left idle on a wrong start byte.");

endmodule

/* sv/cfp_out_reg.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Command frame parser output register
// Holds one result transaction and lets a new one load as the old one leaves.
// ----------------------------------------------------------------------------
module cfp_out_reg (
  input  logic             clk,
  input  logic             rst,
  input  logic             load,
  input  cfp_pkg::result_t result,
  output logic             space,
  output logic             out_valid,
  input  logic             out_stall,
  output cfp_pkg::result_t out_result
);

  logic full;
  cfp_pkg::result_t data;

  assign space = !full || !out_stall;
  assign out_valid = full;
  assign out_result = data;

  always_ff @(posedge clk) begin
    if (rst) begin
      full <= 1'b0;
    end else if (load) begin
      full <= 1'b1;
    end else if (!out_stall) begin
      full <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      data <= result;
    end
  end

endmodule
